// ===== sv/midi_file_event_parser_assert.svh =====
// ----------------------------------------------------------------------------
// MIDI file event parser assertion macros
// Concurrent check macros, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef MIDI_FILE_EVENT_PARSER_ASSERT_SVH
`define MIDI_FILE_EVENT_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MFEP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MFEP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MFEP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define MFEP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/mfep_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI file event parser package
// Phase and result codes, file constants and the result item type.
// ----------------------------------------------------------------------------
package mfep_pkg;

  localparam int unsigned PHASE_W = 5;

  localparam logic [PHASE_W-1:0] PH_HSIG     = 5'd0;
  localparam logic [PHASE_W-1:0] PH_HLEN     = 5'd1;
  localparam logic [PHASE_W-1:0] PH_HFMT     = 5'd2;
  localparam logic [PHASE_W-1:0] PH_HTRK     = 5'd3;
  localparam logic [PHASE_W-1:0] PH_HDIV     = 5'd4;
  localparam logic [PHASE_W-1:0] PH_HSKIP    = 5'd5;
  localparam logic [PHASE_W-1:0] PH_TSIG     = 5'd6;
  localparam logic [PHASE_W-1:0] PH_TLEN     = 5'd7;
  localparam logic [PHASE_W-1:0] PH_DELTA    = 5'd8;
  localparam logic [PHASE_W-1:0] PH_STATUS   = 5'd9;
  localparam logic [PHASE_W-1:0] PH_NOTE     = 5'd10;
  localparam logic [PHASE_W-1:0] PH_VEL      = 5'd11;
  localparam logic [PHASE_W-1:0] PH_SKIP     = 5'd12;
  localparam logic [PHASE_W-1:0] PH_MTYPE    = 5'd13;
  localparam logic [PHASE_W-1:0] PH_MLEN     = 5'd14;
  localparam logic [PHASE_W-1:0] PH_TEMPO    = 5'd15;
  localparam logic [PHASE_W-1:0] PH_DONEPEND = 5'd16;
  localparam logic [PHASE_W-1:0] PH_HALT     = 5'd17;

  localparam logic [2:0] KIND_HEADER   = 3'd0;
  localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
  localparam logic [2:0] KIND_NOTE_OFF = 3'd2;
  localparam logic [2:0] KIND_TEMPO    = 3'd3;
  localparam logic [2:0] KIND_DONE     = 3'd4;
  localparam logic [2:0] KIND_ERROR    = 3'd5;

  localparam logic [23:0] ERR_MTHD_SIG  = 24'd1;
  localparam logic [23:0] ERR_MTRK_SIG  = 24'd2;
  localparam logic [23:0] ERR_SYSEX     = 24'd3;
  localparam logic [23:0] ERR_SYSTEM    = 24'd4;
  localparam logic [23:0] ERR_NO_STATUS = 24'd5;

  localparam logic [31:0] SIG_MTHD = 32'h4D546864;
  localparam logic [31:0] SIG_MTRK = 32'h4D54726B;

  localparam logic [7:0] META_TEMPO      = 8'h51;
  localparam logic [7:0] META_EOT        = 8'h2F;
  localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
  localparam logic [7:0] STATUS_SYSEX_END = 8'hF7;
  localparam logic [7:0] STATUS_META     = 8'hFF;

  // upper status nibbles
  localparam logic [3:0] SH_NOTE_OFF   = 4'h8;
  localparam logic [3:0] SH_NOTE_ON    = 4'h9;
  localparam logic [3:0] SH_POLY_PRESS = 4'hA;
  localparam logic [3:0] SH_CTRL       = 4'hB;
  localparam logic [3:0] SH_PROG       = 4'hC;
  localparam logic [3:0] SH_CHAN_PRESS = 4'hD;
  localparam logic [3:0] SH_PITCH      = 4'hE;
  localparam logic [3:0] SH_SYSTEM     = 4'hF;

  // 0x4000 - 69, A4 maps to 0x4000
  localparam logic [14:0] NOTE_OFFSET = 15'h3FBB;

  localparam logic [31:0] HDR_CORE_LEN = 32'd6;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [31:0] delta_ticks;
    logic [14:0] note_code;
    logic [7:0]  velocity;
    logic [23:0] event_value;
    logic [15:0] track_total;
  } mfep_res_t;

endpackage

// ===== sv/mfep_parser.sv =====
// ----------------------------------------------------------------------------
// MIDI file event parser core
// Byte-wide chunk and event decoder; one file byte per accepted item.
// ----------------------------------------------------------------------------
module mfep_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  logic [7:0]        in_file_byte,
  output logic              res_valid,
  output mfep_pkg::mfep_res_t res,
  output logic              halted
);
  import mfep_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [31:0] byte_counter_r, byte_counter_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [15:0] tracks_r, tracks_nxt;
  logic [7:0]  running_r, running_nxt;
  logic [7:0]  current_r, current_nxt;
  logic [31:0] delta_r, delta_nxt;
  logic [7:0]  note_r, note_nxt;
  logic [7:0]  meta_r, meta_nxt;

  logic [7:0]  b;
  logic [31:0] cnt_inc;
  logic [31:0] cnt_dec;
  logic [31:0] acc8;
  logic [31:0] acc7;
  logic [31:0] extra;
  logic [7:0]  s;
  logic        is_data;

  assign b       = in_file_byte;
  assign cnt_inc = byte_counter_r + 32'd1;
  assign cnt_dec = byte_counter_r - 32'd1;
  assign acc8    = {shift_r[23:0], b};
  assign acc7    = {shift_r[24:0], b[6:0]};
  assign extra   = (delta_r > HDR_CORE_LEN) ? (delta_r - HDR_CORE_LEN) : 32'd0;
  assign is_data = !b[7];
  assign s       = is_data ? running_r : b;
  assign halted  = (phase_r == PH_HALT);

  always_comb begin
    phase_nxt        = phase_r;
    byte_counter_nxt = byte_counter_r;
    shift_nxt        = shift_r;
    tracks_nxt       = tracks_r;
    running_nxt      = running_r;
    current_nxt      = current_r;
    delta_nxt        = delta_r;
    note_nxt         = note_r;
    meta_nxt         = meta_r;
    res_valid        = 1'b0;
    res              = '0;
    if (in_accept) begin
      unique case (phase_r)
        PH_HSIG, PH_HLEN, PH_HFMT, PH_HTRK, PH_TSIG, PH_TLEN: begin
          shift_nxt        = acc8;
          byte_counter_nxt = cnt_inc;
          if (((phase_r == PH_HSIG || phase_r == PH_HLEN || phase_r == PH_TSIG ||
                phase_r == PH_TLEN) && cnt_inc >= 32'd4) ||
              ((phase_r == PH_HFMT || phase_r == PH_HTRK) && cnt_inc >= 32'd2)) begin
            byte_counter_nxt = '0;
            shift_nxt        = '0;
            unique case (phase_r)
              PH_HSIG: begin
                if (acc8 != SIG_MTHD) begin
                  phase_nxt         = PH_HALT;
                  byte_counter_nxt  = cnt_inc;
                  shift_nxt         = acc8;
                  res_valid         = 1'b1;
                  res.event_kind    = KIND_ERROR;
                  res.event_value   = ERR_MTHD_SIG;
                end else begin
                  phase_nxt = PH_HLEN;
                end
              end
              PH_HLEN: begin
                delta_nxt = acc8;
                phase_nxt = PH_HFMT;
              end
              PH_HFMT: phase_nxt = PH_HTRK;
              PH_HTRK: begin
                tracks_nxt = acc8[15:0];
                phase_nxt  = PH_HDIV;
              end
              PH_TSIG: begin
                if (acc8 != SIG_MTRK) begin
                  phase_nxt         = PH_HALT;
                  byte_counter_nxt  = cnt_inc;
                  shift_nxt         = acc8;
                  res_valid         = 1'b1;
                  res.event_kind    = KIND_ERROR;
                  res.event_value   = ERR_MTRK_SIG;
                end else begin
                  phase_nxt = PH_TLEN;
                end
              end
              default: begin
                running_nxt = '0;
                phase_nxt   = PH_DELTA;
              end
            endcase
          end
        end
        PH_HDIV: begin
          shift_nxt        = acc8;
          byte_counter_nxt = cnt_inc;
          if (cnt_inc >= 32'd2) begin
            delta_nxt       = '0;
            res_valid       = 1'b1;
            res.event_kind  = KIND_HEADER;
            res.event_value = {8'd0, acc8[15:0]};
            res.track_total = tracks_r;
            if (extra != 32'd0) begin
              phase_nxt        = PH_HSKIP;
              byte_counter_nxt = extra;
            end else if (tracks_r == 16'd0) begin
              phase_nxt = PH_DONEPEND;
            end else begin
              phase_nxt        = PH_TSIG;
              byte_counter_nxt = '0;
              shift_nxt        = '0;
            end
          end
        end
        PH_HSKIP: begin
          byte_counter_nxt = cnt_dec;
          if (cnt_dec == 32'd0) begin
            if (tracks_r == 16'd0) begin
              phase_nxt      = PH_HALT;
              res_valid      = 1'b1;
              res.event_kind = KIND_DONE;
            end else begin
              phase_nxt = PH_TSIG;
              shift_nxt = '0;
            end
          end
        end
        PH_DELTA: begin
          shift_nxt = acc7;
          if (!b[7]) begin
            delta_nxt = acc7;
            phase_nxt = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (!is_data) begin
            running_nxt = (b >= STATUS_SYSEX) ? 8'd0 : b;
          end
          current_nxt = s;
          unique case (s[7:4]) inside
            SH_NOTE_OFF, SH_NOTE_ON: begin
              if (is_data) begin
                note_nxt  = b;
                phase_nxt = PH_VEL;
              end else begin
                phase_nxt = PH_NOTE;
              end
            end
            SH_POLY_PRESS, SH_CTRL, SH_PITCH: begin
              phase_nxt        = PH_SKIP;
              byte_counter_nxt = is_data ? 32'd1 : 32'd2;
            end
            SH_PROG, SH_CHAN_PRESS: begin
              if (is_data) begin
                phase_nxt        = PH_DELTA;
                byte_counter_nxt = '0;
                shift_nxt        = '0;
              end else begin
                phase_nxt        = PH_SKIP;
                byte_counter_nxt = 32'd1;
              end
            end
            SH_SYSTEM: begin
              if (s == STATUS_SYSEX || s == STATUS_SYSEX_END) begin
                phase_nxt       = PH_HALT;
                res_valid       = 1'b1;
                res.event_kind  = KIND_ERROR;
                res.event_value = ERR_SYSEX;
              end else if (s == STATUS_META) begin
                phase_nxt = PH_MTYPE;
              end else begin
                phase_nxt       = PH_HALT;
                res_valid       = 1'b1;
                res.event_kind  = KIND_ERROR;
                res.event_value = ERR_SYSTEM;
              end
            end
            default: begin
              // data byte with no running status
              phase_nxt       = PH_HALT;
              res_valid       = 1'b1;
              res.event_kind  = KIND_ERROR;
              res.event_value = ERR_NO_STATUS;
            end
          endcase
        end
        PH_NOTE: begin
          note_nxt  = b;
          phase_nxt = PH_VEL;
        end
        PH_VEL: begin
          phase_nxt        = PH_DELTA;
          byte_counter_nxt = '0;
          shift_nxt        = '0;
          res_valid        = 1'b1;
          res.event_kind   = (current_r[7:4] == SH_NOTE_ON) ? KIND_NOTE_ON : KIND_NOTE_OFF;
          res.delta_ticks  = delta_r;
          res.note_code    = {7'd0, note_r} + NOTE_OFFSET;
          res.velocity     = b;
        end
        PH_SKIP: begin
          byte_counter_nxt = cnt_dec;
          if (cnt_dec == 32'd0) begin
            phase_nxt = PH_DELTA;
            shift_nxt = '0;
          end
        end
        PH_MTYPE: begin
          meta_nxt         = b;
          phase_nxt        = PH_MLEN;
          byte_counter_nxt = '0;
          shift_nxt        = '0;
        end
        PH_MLEN: begin
          shift_nxt = acc7;
          if (!b[7]) begin
            if (meta_r == META_TEMPO) begin
              phase_nxt        = PH_TEMPO;
              byte_counter_nxt = '0;
              shift_nxt        = '0;
            end else if (meta_r == META_EOT) begin
              if (tracks_r <= 16'd1) begin
                tracks_nxt     = '0;
                phase_nxt      = PH_HALT;
                res_valid      = 1'b1;
                res.event_kind = KIND_DONE;
              end else begin
                tracks_nxt       = tracks_r - 16'd1;
                phase_nxt        = PH_TSIG;
                byte_counter_nxt = '0;
                shift_nxt        = '0;
              end
            end else if (acc7 == 32'd0) begin
              phase_nxt        = PH_DELTA;
              byte_counter_nxt = '0;
              shift_nxt        = '0;
            end else begin
              phase_nxt        = PH_SKIP;
              byte_counter_nxt = acc7;
            end
          end
        end
        PH_TEMPO: begin
          shift_nxt        = acc8;
          byte_counter_nxt = cnt_inc;
          if (cnt_inc >= 32'd3) begin
            phase_nxt        = PH_DELTA;
            byte_counter_nxt = '0;
            shift_nxt        = '0;
            res_valid        = 1'b1;
            res.event_kind   = KIND_TEMPO;
            res.delta_ticks  = delta_r;
            res.event_value  = acc8[23:0];
          end
        end
        PH_DONEPEND: begin
          phase_nxt      = PH_HALT;
          res_valid      = 1'b1;
          res.event_kind = KIND_DONE;
        end
        default: phase_nxt = PH_HALT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HSIG;
      byte_counter_r <= '0;
      shift_r        <= '0;
      tracks_r       <= '0;
      running_r      <= '0;
      current_r      <= '0;
      delta_r        <= '0;
      note_r         <= '0;
      meta_r         <= '0;
    end else begin
      phase_r        <= phase_nxt;
      byte_counter_r <= byte_counter_nxt;
      shift_r        <= shift_nxt;
      tracks_r       <= tracks_nxt;
      running_r      <= running_nxt;
      current_r      <= current_nxt;
      delta_r        <= delta_nxt;
      note_r         <= note_nxt;
      meta_r         <= meta_nxt;
    end
  end

endmodule

// ===== sv/mfep_out_buf.sv =====
// ----------------------------------------------------------------------------
// MIDI file event parser result buffer
// Output register plus skid entry; input side stalls only when both hold.
// ----------------------------------------------------------------------------
module mfep_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mfep_pkg::mfep_res_t push_res,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output mfep_pkg::mfep_res_t out_res
);
  import mfep_pkg::*;

  logic      main_valid_r, main_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  mfep_res_t main_r, main_nxt;
  mfep_res_t skid_r, skid_nxt;
  logic      pop;

  assign pop       = main_valid_r && out_ready;
  assign space     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_res   = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_res;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ===== sv/midi_file_event_parser.sv =====
// ----------------------------------------------------------------------------
// MIDI file event parser
// Standard MIDI File byte stream in, header/note/tempo/done/error items out.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready with in_file_byte, one file byte per item.
// Output channel: out_valid/out_ready with the result fields; a byte yields
// zero or one result item.
// Throughput: one byte per cycle while in_ready is high; each byte is one
// update of the parse state machine in mfep_parser.
// Result path: a result is registered into the output register, or into the
// skid entry while the output register holds an earlier result not yet taken.
// Stalls: results sit in an output register backed by one skid entry; bytes
// keep flowing while the output waits, and in_ready drops only while both
// entries are full.
// Reset: synchronous, rst_n low; parsing restarts at the header signature
// and the result buffer is emptied. After a done or error result all further
// bytes are taken and discarded until the next reset.
// ----------------------------------------------------------------------------
`include "midi_file_event_parser_assert.svh"

module midi_file_event_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_file_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_kind,
  output logic [31:0] out_delta_ticks,
  output logic [14:0] out_note_code,
  output logic [7:0]  out_velocity,
  output logic [23:0] out_event_value,
  output logic [15:0] out_track_total
);
  import mfep_pkg::*;

  logic      in_accept;
  logic      res_valid;
  logic      halted;
  mfep_res_t res;
  mfep_res_t out_res;

  assign in_accept = in_valid && in_ready;

  mfep_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_accept    (in_accept),
    .in_file_byte (in_file_byte),
    .res_valid    (res_valid),
    .res          (res),
    .halted       (halted)
  );

  mfep_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_res  (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_event_kind  = out_res.event_kind;
  assign out_delta_ticks = out_res.delta_ticks;
  assign out_note_code   = out_res.note_code;
  assign out_velocity    = out_res.velocity;
  assign out_event_value = out_res.event_value;
  assign out_track_total = out_res.track_total;

  `MFEP_ASSERT_IMPLY(a_stall_needs_pending, clk, rst_n, !in_ready, out_valid, "input stalled with no pending item")
  `MFEP_ASSERT_IMPLY(a_halt_silent, clk, rst_n, halted, !res_valid, "result produced after halt")
  `MFEP_ASSERT_IMPLY(a_halt_has_result, clk, rst_n, $rose(halted), $past(res_valid), "halt entered without a result")
  `MFEP_ASSERT_NEXT(a_result_shown, clk, rst_n, res_valid, out_valid, "result item lost")

endmodule

// ===== tb/sv/tb_midi_file_event_parser.sv =====
// ----------------------------------------------------------------------------
// MIDI file event parser testbench
// Streams one MIDI file into the parser: a directed header and track opening,
// then randomised tracks of notes, channel messages, tempo and other meta
// events, ended by end-of-track or by a randomly chosen error. Every result
// item is checked against a cycle-free model of the parser, with random
// gaps on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_midi_file_event_parser;
  import mfep_pkg::*;

  localparam int unsigned TRACK_COUNT    = 12;
  localparam int unsigned HOLD_CYCLES    = 60;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned DIR_ROWS       = 24;
  localparam logic [7:0]  META_TEXT      = 8'h01;

  typedef enum logic [2:0] {
    END_DONE, END_BAD_TRACK, END_SYSEX, END_SYSTEM, END_NO_STATUS
  } file_end_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       typed;
    mfep_res_t  res;
  } dir_row_t;

  localparam mfep_res_t NO_RES = '0;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_file_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_event_kind;
  logic [31:0] out_delta_ticks;
  logic [14:0] out_note_code;
  logic [7:0]  out_velocity;
  logic [23:0] out_event_value;
  logic [15:0] out_track_total;

  int unsigned idle_pct  = 35;
  int unsigned stall_pct = 35;
  logic        hold_req  = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  mfep_res_t   event_fifo [$];

  // parser state mirror
  logic [4:0]  ph       = PH_HSIG;
  logic [31:0] cnt      = '0;
  logic [31:0] acc      = '0;
  logic [31:0] evt_delta = '0;
  logic [15:0] trk_left = '0;
  logic [7:0]  run_st   = '0;
  logic [7:0]  cur_st   = '0;
  logic [7:0]  note_b   = '0;
  logic [7:0]  meta_t   = '0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{8'h4D, 1'b0, NO_RES}, '{8'h54, 1'b0, NO_RES},
    '{8'h68, 1'b0, NO_RES}, '{8'h64, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h08, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h01, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h0C, 1'b0, NO_RES},
    '{8'hE7, 1'b0, NO_RES},
    '{8'h28, 1'b1, '{KIND_HEADER, 32'd0, 15'd0, 8'd0, 24'h00E728, 16'd12}},
    // two header bytes past the core six, skipped
    '{8'h4D, 1'b0, NO_RES}, '{8'h54, 1'b0, NO_RES},
    '{8'h4D, 1'b0, NO_RES}, '{8'h54, 1'b0, NO_RES},
    '{8'h72, 1'b0, NO_RES}, '{8'h6B, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h01, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}
  };

  midi_file_event_parser uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_file_byte    (in_file_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_kind  (out_event_kind),
    .out_delta_ticks (out_delta_ticks),
    .out_note_code   (out_note_code),
    .out_velocity    (out_velocity),
    .out_event_value (out_event_value),
    .out_track_total (out_track_total)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic mfep_res_t mk_res(input logic [2:0] kind, input logic [31:0] dt,
                                       input logic [14:0] nc, input logic [7:0] vel,
                                       input logic [23:0] val, input logic [15:0] trk);
    return '{kind, dt, nc, vel, val, trk};
  endfunction

  function automatic mfep_res_t halt_on(input logic [23:0] code);
    ph = PH_HALT;
    return mk_res(KIND_ERROR, 32'd0, 15'd0, 8'd0, code, 16'd0);
  endfunction

  function automatic bit shift_in(input logic [7:0] b, input int unsigned len);
    acc = {acc[23:0], b};
    cnt = cnt + 1;
    return cnt >= len;
  endfunction

  function automatic void enter(input logic [4:0] p);
    ph  = p;
    cnt = '0;
    acc = '0;
  endfunction

  function automatic void skip_n(input logic [31:0] n);
    if (n == 0) begin
      enter(PH_DELTA);
    end else begin
      ph  = PH_SKIP;
      cnt = n;
    end
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output mfep_res_t r);
    logic [7:0]  s;
    logic [31:0] extra;
    bit          is_data;
    r = '0;
    case (ph)
      PH_HSIG: begin
        if (shift_in(b, 4)) begin
          if (acc != SIG_MTHD) begin
            r = halt_on(ERR_MTHD_SIG);
            return 1'b1;
          end
          enter(PH_HLEN);
        end
      end
      PH_HLEN: begin
        if (shift_in(b, 4)) begin
          evt_delta = acc;
          enter(PH_HFMT);
        end
      end
      PH_HFMT: begin
        if (shift_in(b, 2)) enter(PH_HTRK);
      end
      PH_HTRK: begin
        if (shift_in(b, 2)) begin
          trk_left = acc[15:0];
          enter(PH_HDIV);
        end
      end
      PH_HDIV: begin
        if (!shift_in(b, 2)) return 1'b0;
        r = mk_res(KIND_HEADER, 32'd0, 15'd0, 8'd0, {8'h00, acc[15:0]}, trk_left);
        extra = (evt_delta > HDR_CORE_LEN) ? evt_delta - HDR_CORE_LEN : 32'd0;
        evt_delta = '0;
        if (extra != 0) begin
          ph  = PH_HSKIP;
          cnt = extra;
        end else if (trk_left == 0) begin
          ph = PH_DONEPEND;
        end else begin
          enter(PH_TSIG);
        end
        return 1'b1;
      end
      PH_HSKIP: begin
        cnt = cnt - 1;
        if (cnt == 0) begin
          if (trk_left == 0) begin
            ph = PH_HALT;
            r  = mk_res(KIND_DONE, 32'd0, 15'd0, 8'd0, 24'd0, 16'd0);
            return 1'b1;
          end
          enter(PH_TSIG);
        end
      end
      PH_TSIG: begin
        if (shift_in(b, 4)) begin
          if (acc != SIG_MTRK) begin
            r = halt_on(ERR_MTRK_SIG);
            return 1'b1;
          end
          enter(PH_TLEN);
        end
      end
      PH_TLEN: begin
        if (shift_in(b, 4)) begin
          run_st = '0;
          enter(PH_DELTA);
        end
      end
      PH_DELTA: begin
        acc = {acc[24:0], b[6:0]};
        if (!b[7]) begin
          evt_delta = acc;
          ph = PH_STATUS;
        end
      end
      PH_STATUS: begin
        is_data = !b[7];
        if (is_data) begin
          s = run_st;
        end else begin
          s = b;
          run_st = (b >= 8'hF0) ? 8'h00 : b;
        end
        cur_st = s;
        if (!s[7]) begin
          r = halt_on(ERR_NO_STATUS);
          return 1'b1;
        end
        case (s[7:4])
          SH_NOTE_ON, SH_NOTE_OFF: begin
            if (is_data) begin
              note_b = b;
              ph = PH_VEL;
            end else begin
              ph = PH_NOTE;
            end
          end
          SH_POLY_PRESS, SH_CTRL, SH_PITCH: skip_n(is_data ? 32'd1 : 32'd2);
          SH_PROG, SH_CHAN_PRESS: skip_n(is_data ? 32'd0 : 32'd1);
          default: begin
            if (s == STATUS_SYSEX || s == STATUS_SYSEX_END) begin
              r = halt_on(ERR_SYSEX);
              return 1'b1;
            end else if (s == STATUS_META) begin
              ph = PH_MTYPE;
            end else begin
              r = halt_on(ERR_SYSTEM);
              return 1'b1;
            end
          end
        endcase
      end
      PH_NOTE: begin
        note_b = b;
        ph = PH_VEL;
      end
      PH_VEL: begin
        r = mk_res((cur_st[7:4] == SH_NOTE_ON) ? KIND_NOTE_ON : KIND_NOTE_OFF, evt_delta,
                   15'(note_b) + NOTE_OFFSET, b, 24'd0, 16'd0);
        enter(PH_DELTA);
        return 1'b1;
      end
      PH_SKIP: begin
        cnt = cnt - 1;
        if (cnt == 0) enter(PH_DELTA);
      end
      PH_MTYPE: begin
        meta_t = b;
        enter(PH_MLEN);
      end
      PH_MLEN: begin
        acc = {acc[24:0], b[6:0]};
        if (b[7]) return 1'b0;
        if (meta_t == META_TEMPO) begin
          enter(PH_TEMPO);
        end else if (meta_t == META_EOT) begin
          if (trk_left <= 1) begin
            trk_left = '0;
            ph = PH_HALT;
            r  = mk_res(KIND_DONE, 32'd0, 15'd0, 8'd0, 24'd0, 16'd0);
            return 1'b1;
          end
          trk_left = trk_left - 1;
          enter(PH_TSIG);
        end else begin
          skip_n(acc);
        end
      end
      PH_TEMPO: begin
        if (shift_in(b, 3)) begin
          r = mk_res(KIND_TEMPO, evt_delta, 15'd0, 8'd0, acc[23:0], 16'd0);
          enter(PH_DELTA);
          return 1'b1;
        end
      end
      PH_DONEPEND: begin
        ph = PH_HALT;
        r  = mk_res(KIND_DONE, 32'd0, 15'd0, 8'd0, 24'd0, 16'd0);
        return 1'b1;
      end
      default: ph = PH_HALT;
    endcase
    return 1'b0;
  endfunction

  task automatic feed(input logic [7:0] b, input logic typed, input mfep_res_t typed_res);
    mfep_res_t r;
    bit        got;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_file_byte = b;
    do @(posedge clk); while (!in_ready);
    got = parse_byte(b, r);
    if (typed) begin
      got = 1'b1;
      r = typed_res;
    end
    if (got) event_fifo.push_back(r);
    @(negedge clk);
  endtask

  task automatic put(input logic [7:0] b);
    feed(b, 1'b0, NO_RES);
  endtask

  task automatic put_word(input logic [31:0] w);
    put(w[31:24]);
    put(w[23:16]);
    put(w[15:8]);
    put(w[7:0]);
  endtask

  function automatic logic [7:0] rand7();
    return 8'($urandom_range(0, 127));
  endfunction

  function automatic logic [7:0] pick_vel();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_note();
    case ($urandom_range(0, 19))
      0, 1: return 8'h00;
      2, 3: return 8'h7F;
      4: return 8'($urandom);
      default: return rand7();
    endcase
  endfunction

  task automatic send_delta();
    int unsigned sel;
    int unsigned len;
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      put(8'h8F);
      put(8'hFF);
      put(8'hFF);
      put(8'hFF);
      put(8'h7F);
    end else begin
      len = (sel < 65) ? 1 : (sel < 90) ? $urandom_range(2, 3) : $urandom_range(4, 6);
      repeat (len - 1) put(8'h80 | rand7());
      put(rand7());
    end
  endtask

  task automatic send_event();
    int unsigned sel;
    int unsigned n;
    logic [3:0]  hi;
    logic [7:0]  mt;
    logic [23:0] val;
    send_delta();
    sel = $urandom_range(0, 99);
    if (run_st != 0 && sel < 25) begin
      // running status: data byte stands in for the status
      case (run_st[7:4])
        SH_NOTE_ON, SH_NOTE_OFF: begin
          put(rand7());
          put(pick_vel());
        end
        SH_POLY_PRESS, SH_CTRL, SH_PITCH: begin
          put(rand7());
          put(8'($urandom));
        end
        default: put(rand7());
      endcase
    end else if (sel < 65) begin
      put({($urandom_range(0, 1) != 0) ? SH_NOTE_ON : SH_NOTE_OFF, 4'($urandom)});
      put(pick_note());
      put(pick_vel());
    end else if (sel < 80) begin
      case ($urandom_range(0, 4))
        0: hi = SH_POLY_PRESS;
        1: hi = SH_CTRL;
        2: hi = SH_PROG;
        3: hi = SH_CHAN_PRESS;
        default: hi = SH_PITCH;
      endcase
      put({hi, 4'($urandom)});
      put(8'($urandom));
      if (hi != SH_PROG && hi != SH_CHAN_PRESS) put(8'($urandom));
    end else if (sel < 88) begin
      put(STATUS_META);
      put(META_TEMPO);
      case ($urandom_range(0, 3))
        0: begin
          put(8'h81);
          put(8'h00);
        end
        1: put(rand7());
        default: put(8'h03);
      endcase
      case ($urandom_range(0, 5))
        0: val = 24'h000000;
        1: val = 24'hFFFFFF;
        default: val = 24'($urandom);
      endcase
      put(val[23:16]);
      put(val[15:8]);
      put(val[7:0]);
    end else begin
      mt = 8'($urandom);
      if (mt == META_TEMPO || mt == META_EOT) mt = META_TEXT;
      put(STATUS_META);
      put(mt);
      n = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) put(8'h80);
      put(8'(n));
      repeat (n) put(8'($urandom));
    end
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  task automatic check_item();
    mfep_res_t want;
    if (event_fifo.size() == 0) begin
      $display("%0t: unexpected item, expected none, actual kind %0d value %0h",
               $time, out_event_kind, out_event_value);
      mismatch_cnt++;
    end else begin
      want = event_fifo.pop_front();
      cmp_field("event_kind", 32'(want.event_kind), 32'(out_event_kind));
      cmp_field("delta_ticks", want.delta_ticks, out_delta_ticks);
      cmp_field("note_code", 32'(want.note_code), 32'(out_note_code));
      cmp_field("velocity", 32'(want.velocity), 32'(out_velocity));
      cmp_field("event_value", 32'(want.event_value), 32'(out_event_value));
      cmp_field("track_total", 32'(want.track_total), 32'(out_track_total));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_item();
  end

  always begin
    @(negedge clk);
    if (hold_req && !hold_done) begin
      out_ready = 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_done = 1'b1;
    end
    out_ready = ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    file_end_t   ending;
    int unsigned sel;
    logic [31:0] sig;
    logic [7:0]  st;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) feed(dir_tab[i].file_byte, dir_tab[i].typed, dir_tab[i].res);

    sel = $urandom_range(0, 5);
    ending = (sel < 2) ? END_DONE : file_end_t'(sel - 1);
    sig = SIG_MTRK;

    for (int trk = 1; trk <= TRACK_COUNT; trk++) begin
      if (trk > 1) begin
        if (ending == END_BAD_TRACK && trk == TRACK_COUNT)
          sig = SIG_MTRK ^ (32'd1 << $urandom_range(0, 31));
        put_word(sig);
        put_word($urandom);
      end
      if (sig != SIG_MTRK) break;
      if (trk == 3) begin
        // output held off while a note burst fills the result buffer
        hold_req = 1'b1;
        idle_pct = 0;
        send_delta();
        put({SH_NOTE_ON, 4'($urandom)});
        put(pick_note());
        put(pick_vel());
        repeat (10) begin
          send_delta();
          put(rand7());
          put(pick_vel());
        end
        idle_pct = 35;
      end
      if (trk == 6) begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      if (trk == 8) begin
        idle_pct  = 35;
        stall_pct = 35;
      end
      repeat ($urandom_range(2, 4)) send_event();
      send_delta();
      if (trk < TRACK_COUNT || ending == END_DONE) begin
        put(STATUS_META);
        put(META_EOT);
        put(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 127)) : 8'h00);
      end else begin
        case (ending)
          END_SYSEX: put(($urandom_range(0, 1) != 0) ? STATUS_SYSEX : STATUS_SYSEX_END);
          END_SYSTEM: begin
            st = 8'($urandom_range(8'hF1, 8'hFE));
            if (st == STATUS_SYSEX_END) st = 8'hF1;
            put(st);
          end
          default: begin
            // meta event clears running status, then a bare data byte
            put(STATUS_META);
            put(META_TEXT);
            put(8'h00);
            send_delta();
            put(rand7());
          end
        endcase
      end
    end

    // parser has halted; these bytes are discarded
    repeat (12) put(8'($urandom));
    in_valid = 1'b0;

    while (event_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mfep_pkg.sv
sv/mfep_parser.sv
sv/mfep_out_buf.sv
sv/midi_file_event_parser.sv
tb/sv/tb_midi_file_event_parser.sv
